// ----- rtl/sle_pkg.sv -----
// Shared types, character codes and escape helpers for the string literal escaper.
`default_nettype none
package sle_pkg;

	// Command codes of an input word
	typedef enum logic [1:0] {
		CMD_OPEN  = 2'd0,
		CMD_DATA  = 2'd1,
		CMD_CLOSE = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_PRINT_LO  = 8'h20;
	localparam logic [7:0] CH_PRINT_HI  = 8'h7E;
	localparam logic [7:0] QUOTE_RESET  = 8'd34;

	// One classified word: up to four characters, cnt_m1 is count minus one
	typedef struct packed {
		logic [1:0]      cnt_m1;
		logic [3:0][7:0] chars;
	} esc_entry_t;

	// Queue status seen by the front and back parts
	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	// Backslash letter for control codes 7..13, zero otherwise
	function automatic logic [7:0] letter_escape(input logic [7:0] c);
		logic [7:0] r;
		unique case (c)
			8'd7:    r = 8'h61; // a
			8'd8:    r = 8'h62; // b
			8'd9:    r = 8'h74; // t
			8'd10:   r = 8'h6E; // n
			8'd11:   r = 8'h76; // v
			8'd12:   r = 8'h66; // f
			8'd13:   r = 8'h72; // r
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// Three ASCII decimal digits of a byte, most significant first
	function automatic logic [2:0][7:0] dec_digits(input logic [7:0] c);
		logic [1:0]  h;
		logic [7:0]  rem8;
		logic [6:0]  rem;
		logic [14:0] prod;
		logic [3:0]  tens;
		logic [6:0]  ones;
		logic [2:0][7:0] d;
		if (c >= 8'd200)
			h = 2'd2;
		else if (c >= 8'd100)
			h = 2'd1;
		else
			h = 2'd0;
		rem8 = c - 8'(h) * 8'd100;
		rem  = rem8[6:0];
		// rem * 205 >> 11 is rem / 10 for rem below 100
		prod = 15'(rem) * 15'd205;
		tens = prod[14:11];
		ones = rem - 7'(tens) * 7'd10;
		d[2] = CH_ZERO + 8'(h);
		d[1] = CH_ZERO + 8'(tens);
		d[0] = CH_ZERO + 8'(ones);
		return d;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/string_literal_escaper_top.sv -----
// Top level of the string literal escaper.
// Takes open, data and close words and emits a quoted, escaped literal one
// character per cycle while out_stall is low. Open and close each emit the
// delimiter; a data byte emits one, two or four characters (plain, backslash
// pair, or backslash and three decimal digits); command 3 emits nothing. A
// word is classified in the cycle it is accepted and queued; the back end
// drives its characters one at a time out of a registered output, so the
// output character rate sets the sustained throughput. An accepted word is
// written into the queue, and its first character then into the output
// register. The delimiter register should be written only while no words
// are in flight.
`default_nettype none
module string_literal_escaper_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] cmd,
	input  wire logic [7:0] data_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_char,
	output logic            last
);
	import sle_pkg::*;

	q_stat_t    q_stat;
	esc_entry_t push_entry;
	esc_entry_t head;
	logic       push;
	logic       pop;

	sle_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.cmd        (cmd),
		.data_byte  (data_byte),
		.q_stat     (q_stat),
		.in_stall   (in_stall),
		.push       (push),
		.push_entry (push_entry)
	);

	sle_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat)
	);

	sle_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.out_stall (out_stall),
		.pop       (pop),
		.out_valid (out_valid),
		.out_char  (out_char),
		.last      (last)
	);

endmodule
`default_nettype wire

// ----- rtl/sle_front.sv -----
// Front part: holds the delimiter register and classifies each input word.
`default_nettype none
module sle_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [7:0]          cfg_wdata,
	input  wire logic                in_valid,
	input  wire logic [1:0]          cmd,
	input  wire logic [7:0]          data_byte,
	input  wire sle_pkg::q_stat_t    q_stat,
	output logic                     in_stall,
	output logic                     push,
	output sle_pkg::esc_entry_t      push_entry
);
	import sle_pkg::*;

	logic [7:0] quote_q;
	logic [7:0] letter;
	logic [2:0][7:0] digits;
	cmd_t cmd_c;

	// Delimiter register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			quote_q <= QUOTE_RESET;
		else if (cfg_we)
			quote_q <= cfg_wdata;
	end

	assign cmd_c  = cmd_t'(cmd);
	assign letter = letter_escape(data_byte);
	assign digits = dec_digits(data_byte);

	// Handshake: stall only on a full queue; undefined commands are dropped
	assign in_stall = q_stat.full;
	assign push     = in_valid && !q_stat.full && (cmd_c != CMD_NONE);

	// Classification into an escape sequence
	always_comb begin
		push_entry.cnt_m1 = 2'd0;
		push_entry.chars  = '0;
		unique case (cmd_c)
			CMD_OPEN, CMD_CLOSE: begin
				push_entry.chars[0] = quote_q;
			end
			CMD_DATA: begin
				priority if (data_byte == quote_q) begin
					push_entry.cnt_m1   = 2'd1;
					push_entry.chars[0] = CH_BACKSLASH;
					push_entry.chars[1] = quote_q;
				end else if (data_byte == CH_BACKSLASH) begin
					push_entry.cnt_m1   = 2'd1;
					push_entry.chars[0] = CH_BACKSLASH;
					push_entry.chars[1] = CH_BACKSLASH;
				end else if (data_byte >= CH_PRINT_LO && data_byte <= CH_PRINT_HI) begin
					push_entry.chars[0] = data_byte;
				end else if (letter != 8'h00) begin
					push_entry.cnt_m1   = 2'd1;
					push_entry.chars[0] = CH_BACKSLASH;
					push_entry.chars[1] = letter;
				end else begin
					push_entry.cnt_m1   = 2'd3;
					push_entry.chars[0] = CH_BACKSLASH;
					push_entry.chars[1] = digits[2];
					push_entry.chars[2] = digits[1];
					push_entry.chars[3] = digits[0];
				end
			end
			default: begin
				push_entry.chars = '0;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/sle_queue.sv -----
// Short queue of classified words between the front and back parts.
`default_nettype none
module sle_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire sle_pkg::esc_entry_t push_entry,
	input  wire logic                pop,
	output sle_pkg::esc_entry_t      head,
	output sle_pkg::q_stat_t         q_stat
);
	import sle_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	esc_entry_t      mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign q_stat.empty = (count_q == '0);
	assign q_stat.full  = (count_q == FULL_CNT);
	assign do_push = push && !q_stat.full;
	assign do_pop  = pop && !q_stat.empty;
	assign head    = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/sle_back.sv -----
// Back part: walks the head word's characters into the output register.
`default_nettype none
module sle_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire sle_pkg::esc_entry_t head,
	input  wire sle_pkg::q_stat_t    q_stat,
	input  wire logic                out_stall,
	output logic                     pop,
	output logic                     out_valid,
	output logic [7:0]               out_char,
	output logic                     last
);
	import sle_pkg::*;

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       last_q;
	logic       load;
	logic       at_end;

	// Output register may take a new character when empty or being drained
	assign load   = !out_valid_q || !out_stall;
	assign at_end = (idx_q == head.cnt_m1);
	assign pop    = load && !q_stat.empty && at_end;

	// Character index and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= !q_stat.empty;
			if (!q_stat.empty)
				idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (load && !q_stat.empty) begin
			out_char_q <= head.chars[idx_q];
			last_q     <= at_end;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign last      = last_q;

endmodule
`default_nettype wire

// ----- test/string_literal_escaper_top_tb.sv -----
// Self-checking testbench for the string literal escaper: directed table plus random literals.
`timescale 1ns / 1ps
module string_literal_escaper_top_tb;
	import sle_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;

	// One emitted character of the literal and its end-of-word flag
	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} lit_char_t;

	// One stimulus word; typed rows carry their expected text, right-justified
	typedef struct packed {
		cmd_t        cmd;
		logic [7:0]  data;
		logic        typed;
		logic [2:0]  n_chars;
		logic [31:0] text;
	} word_row_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;
	logic       in_valid;
	logic       in_stall;
	logic [1:0] cmd;
	logic [7:0] data_byte;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] out_char;
	logic       last;

	word_row_t  cur_row;
	word_row_t  dir_rows [$];
	lit_char_t  pending_chars [$];
	logic [7:0] quote_reg;
	int         mismatches;
	int         words_taken;
	int         chars_seen;
	int         quote_settings;
	int         burst_left;
	int         idle_cycles;

	string_literal_escaper_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.data_byte (data_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_char  (out_char),
		.last      (last)
	);

	always #6 clk = ~clk;

	// Escaped characters for one word under delimiter q; returns the count
	function automatic int escape_word(input logic [1:0] c, input logic [7:0] b,
			input logic [7:0] q, output logic [3:0][7:0] seq);
		int n;
		seq = '0;
		n = 0;
		if (c == CMD_OPEN || c == CMD_CLOSE) begin
			seq[0] = q;
			n = 1;
		end else if (c == CMD_DATA) begin
			seq[0] = 8'h5C;
			n = 2;
			// delimiter check wins over every other class
			if (b == q)
				seq[1] = q;
			else if (b == 8'h5C)
				seq[1] = 8'h5C;
			else if (b >= 8'h20 && b <= 8'h7E) begin
				seq[0] = b;
				n = 1;
			end else begin
				case (b)
					8'd7:  seq[1] = "a";
					8'd8:  seq[1] = "b";
					8'd9:  seq[1] = "t";
					8'd10: seq[1] = "n";
					8'd11: seq[1] = "v";
					8'd12: seq[1] = "f";
					8'd13: seq[1] = "r";
					default: begin
						seq[1] = 8'h30 + b / 8'd100;
						seq[2] = 8'h30 + (b / 8'd10) % 8'd10;
						seq[3] = 8'h30 + b % 8'd10;
						n = 4;
					end
				endcase
			end
		end
		return n;
	endfunction

	function automatic word_row_t mk_row(input cmd_t c, input logic [7:0] b, input logic typed,
			input logic [2:0] n, input logic [31:0] text);
		word_row_t r;
		r.cmd = c;
		r.data = b;
		r.typed = typed;
		r.n_chars = n;
		r.text = text;
		return r;
	endfunction

	// Data byte biased toward the delimiter, backslash, controls and high bytes
	function automatic logic [7:0] pick_byte(input logic [7:0] q);
		int r;
		r = $urandom_range(0, 99);
		if (r < 12) return q;
		if (r < 22) return 8'h5C;
		if (r < 34) return 8'($urandom_range(7, 13));
		if (r < 50) return 8'($urandom_range(0, 31));
		if (r < 62) return 8'($urandom_range(128, 255));
		if (r < 75) return 8'($urandom_range(32, 126));
		return 8'($urandom_range(0, 255));
	endfunction

	// Offer one word in a burst pattern and hold it until accepted
	task automatic send_word(input word_row_t row);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				cmd <= 2'($urandom);
				data_byte <= 8'($urandom);
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		cmd <= row.cmd;
		data_byte <= row.data;
		cur_row <= row;
		do @(posedge clk); while (in_stall);
	endtask

	// Drain the block, let any silent word clear, then write the delimiter
	task automatic set_quote(input logic [7:0] v);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_chars.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		quote_settings++;
	endtask

	// Mostly well-formed literals with random content, some noise words
	task automatic run_literals(input int quota);
		int counted;
		int len;
		word_row_t row;
		counted = 0;
		while (counted < quota) begin
			if ($urandom_range(0, 99) < 85) begin
				send_word(mk_row(CMD_OPEN, 8'($urandom), 1'b0, 3'd0, 32'd0));
				counted++;
				len = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 10);
				repeat (len) begin
					send_word(mk_row(CMD_DATA, pick_byte(quote_reg), 1'b0, 3'd0, 32'd0));
					counted++;
				end
				// now and then a literal is left unclosed
				if ($urandom_range(0, 19) != 0) begin
					send_word(mk_row(CMD_CLOSE, 8'($urandom), 1'b0, 3'd0, 32'd0));
					counted++;
				end
			end else begin
				row = mk_row(cmd_t'($urandom_range(0, 3)), 8'($urandom), 1'b0, 3'd0, 32'd0);
				send_word(row);
				if (row.cmd != CMD_NONE)
					counted++;
			end
		end
	endtask

	// Predict on accepted words, check accepted characters
	always @(posedge clk) begin : monitor
		logic [3:0][7:0] seq;
		int n;
		lit_char_t want;
		if (!arst_n) begin
			quote_reg = 8'h22;
		end else begin
			if (in_valid && !in_stall) begin
				words_taken++;
				if (cur_row.typed) begin
					n = cur_row.n_chars;
					for (int k = 0; k < n; k++)
						seq[k] = cur_row.text[8 * (n - 1 - k) +: 8];
				end else begin
					n = escape_word(cmd, data_byte, quote_reg, seq);
				end
				for (int k = 0; k < n; k++)
					pending_chars.push_back('{seq[k], k == n - 1});
			end
			if (cfg_we)
				quote_reg = cfg_wdata;
			if (out_valid && !out_stall) begin
				chars_seen++;
				if (pending_chars.size() == 0) begin
					$display("%0t: unexpected char: expected none, got %h last %b",
						$time, out_char, last);
					mismatches++;
				end else begin
					want = pending_chars.pop_front();
					if (out_char !== want.ch) begin
						$display("%0t: out_char mismatch: expected %h, got %h",
							$time, want.ch, out_char);
						mismatches++;
					end
					if (last !== want.last) begin
						$display("%0t: last mismatch: expected %b, got %b",
							$time, want.last, last);
						mismatches++;
					end
				end
			end
		end
	end

	// Watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, idle_cycles);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// Receiver: free runs, random stalls, and a long hold every seventh phase
	initial begin : receiver
		int phase_no;
		int span;
		int duty;
		phase_no = 0;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (phase_no % 7 == 0) begin
				span = $urandom_range(40, 80);
				repeat (span) begin
					@(negedge clk);
					out_stall <= 1'b1;
				end
			end else if ($urandom_range(0, 2) == 0) begin
				span = $urandom_range(10, 30);
				repeat (span) begin
					@(negedge clk);
					out_stall <= 1'b0;
				end
			end else begin
				span = $urandom_range(10, 30);
				duty = $urandom_range(1, 7);
				repeat (span) begin
					@(negedge clk);
					out_stall <= ($urandom_range(0, 9) < duty);
				end
			end
			phase_no++;
		end
	end

	// Main sequence: reset, directed table, then random literals per delimiter
	initial begin
		logic [7:0] quote_plan [8];
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 8'h00;
		in_valid = 1'b0;
		cmd = CMD_NONE;
		data_byte = 8'h00;
		cur_row = '0;
		mismatches = 0;
		words_taken = 0;
		chars_seen = 0;
		quote_settings = 0;
		burst_left = 0;
		idle_cycles = 0;
		quote_plan = '{8'h27, 8'h5C, 8'h00, 8'hFF, 8'h0A, 8'hC8, 8'h00, 8'h22};
		quote_plan[6] = 8'($urandom);

		// Directed words under the reset delimiter
		dir_rows.push_back(mk_row(CMD_OPEN,  8'h00, 1'b1, 3'd1, "\""));
		dir_rows.push_back(mk_row(CMD_DATA,  8'h41, 1'b1, 3'd1, "A"));
		dir_rows.push_back(mk_row(CMD_DATA,  8'h20, 1'b1, 3'd1, " "));
		dir_rows.push_back(mk_row(CMD_DATA,  8'h7E, 1'b1, 3'd1, "~"));
		dir_rows.push_back(mk_row(CMD_DATA,  8'h22, 1'b1, 3'd2, "\\\""));
		dir_rows.push_back(mk_row(CMD_DATA,  8'h5C, 1'b1, 3'd2, "\\\\"));
		dir_rows.push_back(mk_row(CMD_DATA,  8'h00, 1'b1, 3'd4, "\\000"));
		dir_rows.push_back(mk_row(CMD_DATA,  8'hFF, 1'b1, 3'd4, "\\255"));
		dir_rows.push_back(mk_row(CMD_DATA,  8'h07, 1'b1, 3'd2, "\\a"));
		dir_rows.push_back(mk_row(CMD_DATA,  8'h0D, 1'b1, 3'd2, "\\r"));
		dir_rows.push_back(mk_row(CMD_DATA,  8'h08, 1'b0, 3'd0, 32'd0));
		dir_rows.push_back(mk_row(CMD_DATA,  8'h09, 1'b0, 3'd0, 32'd0));
		dir_rows.push_back(mk_row(CMD_DATA,  8'h0A, 1'b0, 3'd0, 32'd0));
		dir_rows.push_back(mk_row(CMD_DATA,  8'h0B, 1'b0, 3'd0, 32'd0));
		dir_rows.push_back(mk_row(CMD_DATA,  8'h0C, 1'b0, 3'd0, 32'd0));
		dir_rows.push_back(mk_row(CMD_DATA,  8'h06, 1'b0, 3'd0, 32'd0));
		dir_rows.push_back(mk_row(CMD_DATA,  8'h0E, 1'b0, 3'd0, 32'd0));
		dir_rows.push_back(mk_row(CMD_DATA,  8'h1F, 1'b0, 3'd0, 32'd0));
		dir_rows.push_back(mk_row(CMD_DATA,  8'h7F, 1'b1, 3'd4, "\\127"));
		dir_rows.push_back(mk_row(CMD_DATA,  8'h80, 1'b0, 3'd0, 32'd0));
		dir_rows.push_back(mk_row(CMD_DATA,  8'h64, 1'b0, 3'd0, 32'd0));
		// undefined command is silent; data is ignored on open and close
		dir_rows.push_back(mk_row(CMD_NONE,  8'hFF, 1'b1, 3'd0, 32'd0));
		dir_rows.push_back(mk_row(CMD_OPEN,  8'hAA, 1'b1, 3'd1, "\""));
		dir_rows.push_back(mk_row(CMD_CLOSE, 8'h5C, 1'b1, 3'd1, "\""));
		dir_rows.push_back(mk_row(CMD_CLOSE, 8'h55, 1'b1, 3'd1, "\""));

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			send_word(dir_rows[i]);

		// Random literals under each delimiter, extremes included
		foreach (quote_plan[i]) begin
			set_quote(quote_plan[i]);
			run_literals(54);
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_chars.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);

		$display("Run covered %0d accepted words and %0d output chars", words_taken, chars_seen);
		$display("over %0d delimiter writes plus the reset delimiter", quote_settings);
		if (mismatches == 0 && pending_chars.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/sle_pkg.sv
rtl/sle_front.sv
rtl/sle_queue.sv
rtl/sle_back.sv
rtl/string_literal_escaper_top.sv
test/string_literal_escaper_top_tb.sv
